[hdl/rme_pkg.sv]
// shared types, constants and helper functions for the euler angle extractor
package rme_pkg;

    localparam int ENTRY_FRAC_BITS = 14;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int Z_FRAC          = 30;
    localparam int CORDIC_STEPS    = 30;
    localparam int STEP_W          = $clog2(CORDIC_STEPS);

    localparam int ENTRY_W = 16;
    localparam int SQ_W    = 2 * ENTRY_W;          // one square
    localparam int RAD_W   = SQ_W + 2;             // sum of two squares, padded to pairs
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 4;
    localparam int SQRT_STEPS = ROOT_W;

    localparam int OPD_W  = ROOT_W + 1;            // signed operand before scaling
    localparam int SCALE  = Z_FRAC - ENTRY_FRAC_BITS;
    localparam int CW     = OPD_W + SCALE + 2;     // cordic x and y
    localparam int ZW     = Z_FRAC + 5;            // cordic angle accumulator
    localparam int ANG_W  = 16;
    localparam int PITCH_W = 15;
    localparam int LIMIT_W = 15;

    localparam logic signed [ZW-1:0] PI_Z = ZW'(64'sd3373259426);
    localparam int SH = Z_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] HALF_Z = ZW'(64'sd1 <<< (SH - 1));
    localparam logic signed [ZW-1:0] PI_ANG = (PI_Z + HALF_Z) >>> SH;

    typedef struct packed {
        logic signed [ENTRY_W-1:0] r00;
        logic signed [ENTRY_W-1:0] r10;
        logic signed [ENTRY_W-1:0] r11;
        logic signed [ENTRY_W-1:0] r12;
        logic signed [ENTRY_W-1:0] r20;
        logic signed [ENTRY_W-1:0] r21;
        logic signed [ENTRY_W-1:0] r22;
    } mat_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        mat_t              m;
    } sqrt_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

    // atan(2^-i) in q.30, truncated, except the last three entries, which are rounded
    function automatic logic signed [ZW-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            default: v = 32'h0;
        endcase
        return ZW'(v);
    endfunction

    // fold the left half plane onto the right one and scale to q.30
    function automatic cordic_t cordic_prep(input logic signed [OPD_W-1:0] y,
                                            input logic signed [OPD_W-1:0] x);
        cordic_t r;
        logic signed [CW-1:0] xe;
        logic signed [CW-1:0] ye;
        xe = CW'(x);
        ye = CW'(y);
        r.z = '0;
        if (x < 0) begin
            r.z = (y >= 0) ? PI_Z : -PI_Z;
            xe = -xe;
            ye = -ye;
        end
        r.x = xe <<< SCALE;
        r.y = ye <<< SCALE;
        return r;
    endfunction

    // round half up to the output precision and clamp to +-pi
    function automatic logic signed [ANG_W-1:0] to_angle(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] q;
        q = (z + HALF_Z) >>> SH;
        if (q > PI_ANG) q = PI_ANG;
        if (q < -PI_ANG) q = -PI_ANG;
        return q[ANG_W-1:0];
    endfunction

endpackage

[hdl/rotation_matrix_to_euler.sv]
// top level: rotation matrix to x-y-z euler angles, fully pipelined
// stages from input word to result word: input register, squares,
// sum, 17 square root cells, operand select, 30 cordic cells, output rounding
// throughput one word per cycle; the whole pipe stalls only while m_tready holds off a result
// reset (aresetn low, synchronous) clears all valid bits and sets singular_limit to 1
module rotation_matrix_to_euler (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [111:0]                 s_tdata,   // r00, r10, r11, r12, r20, r21, r22
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [47:0]                  m_tdata,   // roll_angle, pitch_angle, yaw_angle, pad
    output logic                         m_tuser,   // singular_flag
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rme_pkg::LIMIT_W-1:0]  cfg_data   // singular_limit
);
    import rme_pkg::*;

    // global advance: everything moves when the output slot is free or being emptied
    logic en;
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // threshold register
    logic [LIMIT_W-1:0] limit_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_W'(1);
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    // stage 0: input register
    logic v0_reg;
    mat_t m0_reg;
    mat_t m_in;
    assign m_in.r00 = s_tdata[15:0];
    assign m_in.r10 = s_tdata[31:16];
    assign m_in.r11 = s_tdata[47:32];
    assign m_in.r12 = s_tdata[63:48];
    assign m_in.r20 = s_tdata[79:64];
    assign m_in.r21 = s_tdata[95:80];
    assign m_in.r22 = s_tdata[111:96];

    // stage 1: the two squares, stage 2: their sum
    logic v1_reg, v2_reg;
    mat_t m1_reg;
    logic [SQ_W-1:0] sqa_reg, sqb_reg;
    sqrt_t s2_reg;
    logic signed [SQ_W-1:0] sqa_next, sqb_next;
    assign sqa_next = m0_reg.r00 * m0_reg.r00;
    assign sqb_next = m0_reg.r10 * m0_reg.r10;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m0_reg      <= m_in;
            m1_reg      <= m0_reg;
            sqa_reg     <= sqa_next;
            sqb_reg     <= sqb_next;
            s2_reg.rad  <= RAD_W'(sqa_reg) + RAD_W'(sqb_reg);
            s2_reg.rem  <= '0;
            s2_reg.root <= '0;
            s2_reg.m    <= m1_reg;
        end
    end

    // square root: one result bit per cell
    logic  sv [0:SQRT_STEPS];
    sqrt_t sd [0:SQRT_STEPS];
    assign sv[0] = v2_reg;
    assign sd[0] = s2_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        rme_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (sv[k]),
            .d_in      (sd[k]),
            .valid_out (sv[k+1]),
            .d_out     (sd[k+1])
        );
    end

    // operand select: gimbal lock test picks the roll operands
    logic [ROOT_W-1:0] sy;
    mat_t              mq;
    logic              sing;
    assign sy   = sd[SQRT_STEPS].root;
    assign mq   = sd[SQRT_STEPS].m;
    assign sing = sy < ROOT_W'(limit_reg);

    logic    vp_reg, sp_reg;
    cordic_t lane [0:CORDIC_STEPS][0:2];   // lanes: roll, pitch, yaw
    cordic_t lp_reg [0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg <= 1'b0;
        end else if (en) begin
            vp_reg <= sv[SQRT_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sp_reg    <= sing;
            lp_reg[0] <= sing ? cordic_prep(-OPD_W'(mq.r12), OPD_W'(mq.r11))
                              : cordic_prep(OPD_W'(mq.r21), OPD_W'(mq.r22));
            lp_reg[1] <= cordic_prep(-OPD_W'(mq.r20), OPD_W'({1'b0, sy}));
            lp_reg[2] <= cordic_prep(OPD_W'(mq.r10), OPD_W'(mq.r00));
        end
    end

    // cordic chain: three lanes side by side, one micro-rotation per cell
    logic cv_reg [0:CORDIC_STEPS];
    logic cs_reg [0:CORDIC_STEPS];
    assign cv_reg[0] = vp_reg;
    assign cs_reg[0] = sp_reg;

    for (genvar j = 0; j < 3; j++) begin : g_lane_in
        assign lane[0][j] = lp_reg[j];
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cv_reg[k+1] <= 1'b0;
            end else if (en) begin
                cv_reg[k+1] <= cv_reg[k];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                cs_reg[k+1] <= cs_reg[k];
            end
        end
        for (genvar j = 0; j < 3; j++) begin : g_lane
            rme_cordic_cell u_cell (
                .aclk  (aclk),
                .en    (en),
                .step  (STEP_W'(k)),
                .d_in  (lane[k][j]),
                .d_out (lane[k+1][j])
            );
        end
    end

    // output register: rounding, clamp and yaw forced to zero in gimbal lock
    logic                     m_tvalid_reg;
    logic signed [ANG_W-1:0]  roll_reg, pitch_reg, yaw_reg;
    logic                     sing_reg;
    logic signed [ANG_W-1:0]  roll_next, pitch_next, yaw_next;

    assign roll_next  = to_angle(lane[CORDIC_STEPS][0].z);
    assign pitch_next = to_angle(lane[CORDIC_STEPS][1].z);
    assign yaw_next   = cs_reg[CORDIC_STEPS] ? '0 : to_angle(lane[CORDIC_STEPS][2].z);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= cv_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
            sing_reg  <= cs_reg[CORDIC_STEPS];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, yaw_reg, pitch_reg[PITCH_W-1:0], roll_reg};
    assign m_tuser  = sing_reg;

endmodule

[hdl/rme_sqrt_cell.sv]
// one digit of the pipelined integer square root, carrying the matrix along
module rme_sqrt_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              valid_in,
    input  rme_pkg::sqrt_t    d_in,
    output logic              valid_out,
    output rme_pkg::sqrt_t    d_out
);
    import rme_pkg::*;

    logic              valid_reg;
    sqrt_t             data_reg;
    sqrt_t             data_next;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    always_comb begin
        rem_sh = {d_in.rem[REM_W-3:0], d_in.rad[RAD_W-1 -: 2]};
        trial  = REM_W'({d_in.root, 2'b01});
        data_next     = d_in;
        data_next.rad = {d_in.rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            data_next.rem  = rem_sh - trial;
            data_next.root = {d_in.root[ROOT_W-2:0], 1'b1};
        end else begin
            data_next.rem  = rem_sh;
            data_next.root = {d_in.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign d_out     = data_reg;

endmodule

[hdl/rme_cordic_cell.sv]
// one vectoring micro-rotation of an atan2 lane
module rme_cordic_cell (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [rme_pkg::STEP_W-1:0] step,
    input  rme_pkg::cordic_t           d_in,
    output rme_pkg::cordic_t           d_out
);
    import rme_pkg::*;

    cordic_t data_reg;
    cordic_t data_next;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    always_comb begin
        xs = d_in.x >>> step;
        ys = d_in.y >>> step;
        data_next = d_in;
        if (d_in.y > 0) begin
            data_next.x = d_in.x + ys;
            data_next.y = d_in.y - xs;
            data_next.z = d_in.z + atan_entry(step);
        end else if (d_in.y < 0) begin
            data_next.x = d_in.x - ys;
            data_next.y = d_in.y + xs;
            data_next.z = d_in.z - atan_entry(step);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign d_out = data_reg;

endmodule

[hdl/rme_check.sv]
// port level checks for the euler angle extractor, bound to the top level
module rme_check (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [47:0]  m_tdata,
    input logic         m_tuser
);

    // a locked result reports zero yaw
    a_yaw_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[46:31] == 16'd0)
        else $error("yaw not zero in gimbal lock");

    // input side stalls whenever a result is held off
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output stalled");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind rotation_matrix_to_euler rme_check u_rme_check (.*);

[bench/tb.sv]
// testbench for the rotation matrix to euler angle extractor
module tb;
    import rme_pkg::*;

    // one extracted angle set as it appears on the result stream
    typedef struct {
        logic [15:0] roll;
        logic [14:0] pitch;
        logic [15:0] yaw;
        logic        singular;
    } angles_t;

    localparam int PIPE_DRAIN = 70;        // comfortably past the full pipeline from input to result
    localparam longint PI_FIXED = 64'sd3373259426;
    localparam longint ATAN_ROM [30] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
    };

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;     // r00, r10, r11, r12, r20, r21, r22
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;     // roll_angle, pitch_angle, yaw_angle, pad
    logic         m_tuser;     // singular_flag
    logic         cfg_valid;
    logic         cfg_ready;
    logic [LIMIT_W-1:0] cfg_data;  // singular_limit

    rotation_matrix_to_euler uut (.*);

    angles_t      pending_angles[$];
    logic [14:0]  gimbal_limit;    // our copy of singular_limit
    bit           quiet_tail;      // no idling on either side in the final stretch
    int           errors;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end

    // vectoring cordic, folded to the right half plane, q.30 angle
    function automatic longint cordic_atan2(longint y, longint x);
        longint z, t;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_FIXED : -PI_FIXED;
            x = -x;
            y = -y;
        end
        x = x * 65536;
        y = y * 65536;
        for (int i = 0; i < 30; i++) begin
            if (y == 0) break;
            if (y > 0) begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                x = t;
                z += ATAN_ROM[i];
            end else begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                x = t;
                z -= ATAN_ROM[i];
            end
        end
        return z;
    endfunction

    // round half up to q2.13 and clamp to +-pi
    function automatic longint angle_q13(longint y, longint x);
        longint q, pi_q;
        pi_q = (PI_FIXED + 65536) >>> 17;
        q = (cordic_atan2(y, x) + 65536) >>> 17;
        if (q > pi_q) q = pi_q;
        if (q < -pi_q) q = -pi_q;
        return q;
    endfunction

    function automatic longint floor_sqrt(longint v);
        longint root, bitv;
        root = 0;
        bitv = 64'sd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >>> 1) + bitv;
            end else begin
                root >>>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic angles_t extract_angles(mat_t m);
        angles_t a;
        longint sy;
        sy = floor_sqrt(longint'(m.r00) * m.r00 + longint'(m.r10) * m.r10);
        a.singular = (sy < longint'(gimbal_limit));
        a.pitch = 15'(angle_q13(-longint'(m.r20), sy));
        if (!a.singular) begin
            a.roll = 16'(angle_q13(m.r21, m.r22));
            a.yaw  = 16'(angle_q13(m.r10, m.r00));
        end else begin
            // gimbal lock: roll from the second row, yaw forced to zero
            a.roll = 16'(angle_q13(-longint'(m.r12), m.r11));
            a.yaw  = '0;
        end
        return a;
    endfunction

    // input monitor: predict on every accepted word
    always @(posedge aclk) begin
        mat_t m;
        if (aresetn && s_tvalid && s_tready) begin
            m.r00 = s_tdata[15:0];   m.r10 = s_tdata[31:16];
            m.r11 = s_tdata[47:32];  m.r12 = s_tdata[63:48];
            m.r20 = s_tdata[79:64];  m.r21 = s_tdata[95:80];
            m.r22 = s_tdata[111:96];
            pending_angles = {pending_angles, extract_angles(m)};
        end
    end

    // result checker
    always @(posedge aclk) begin
        angles_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_angles.size() == 0) begin
                $display("%0t: unexpected result word %h user %b", $time, m_tdata, m_tuser);
                errors++;
            end else begin
                want = pending_angles.pop_front();
                if (m_tdata[15:0] !== want.roll) begin
                    $display("%0t: roll expected %h actual %h", $time, want.roll,
                             m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[30:16] !== want.pitch) begin
                    $display("%0t: pitch expected %h actual %h", $time, want.pitch,
                             m_tdata[30:16]);
                    errors++;
                end
                if (m_tdata[46:31] !== want.yaw) begin
                    $display("%0t: yaw expected %h actual %h", $time, want.yaw,
                             m_tdata[46:31]);
                    errors++;
                end
                if (m_tuser !== want.singular) begin
                    $display("%0t: singular expected %b actual %b", $time, want.singular,
                             m_tuser);
                    errors++;
                end
            end
        end
    end

    // receiver back-pressure in random bursts
    initial begin
        int burst;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (quiet_tail) begin
                m_tready <= 1'b1;
            end else if (burst > 0) begin
                burst--;
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                burst = $urandom_range(1, 12) - 1;
            end else begin
                m_tready <= 1'b1;
                burst = $urandom_range(0, 15);
            end
        end
    end

    task automatic send_matrix(mat_t m);
        int gap;
        @(negedge aclk);
        if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {m.r22, m.r21, m.r20, m.r12, m.r11, m.r10, m.r00};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    task automatic drain_pipe();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_angles.size() != 0) @(posedge aclk);
        repeat (PIPE_DRAIN) @(posedge aclk);
    endtask

    task automatic write_limit(logic [14:0] value);
        drain_pipe();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        gimbal_limit = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic mat_t entries(int a, int b, int c, int d, int e, int f, int g);
        mat_t m;
        m.r00 = 16'(a); m.r10 = 16'(b); m.r11 = 16'(c); m.r12 = 16'(d);
        m.r20 = 16'(e); m.r21 = 16'(f); m.r22 = 16'(g);
        return m;
    endfunction

    function automatic logic [15:0] q14(real v);
        return 16'($rtoi(v * 16384.0 + (v >= 0 ? 0.5 : -0.5)));
    endfunction

    // rz(yaw) * ry(pitch) * rx(roll), with the entries rounded to q.14
    function automatic mat_t rotation(real roll, real pitch, real yaw);
        mat_t m;
        real cr, sr, cp, sp, cy, syw;
        cr = $cos(roll);  sr = $sin(roll);
        cp = $cos(pitch); sp = $sin(pitch);
        cy = $cos(yaw);   syw = $sin(yaw);
        m.r00 = q14(cy * cp);
        m.r10 = q14(syw * cp);
        m.r11 = q14(syw * sp * sr + cy * cr);
        m.r12 = q14(syw * sp * cr - cy * sr);
        m.r20 = q14(-sp);
        m.r21 = q14(cp * sr);
        m.r22 = q14(cp * cr);
        return m;
    endfunction

    function automatic real rand_angle(real span);
        return span * (($urandom_range(0, 2000000) / 1000000.0) - 1.0);
    endfunction

    task automatic test_directed();
        // identity, zero matrix, the range extremes and the out-of-range entry
        send_matrix(entries(16384, 0, 16384, 0, 0, 0, 16384));
        send_matrix(entries(0, 0, 0, 0, 0, 0, 0));
        send_matrix(entries(16384, 16384, 16384, 16384, 16384, 16384, 16384));
        send_matrix(entries(-16384, -16384, -16384, -16384, -16384, -16384, -16384));
        send_matrix(entries(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_matrix(entries(32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_matrix(entries(-32768, 0, 0, -32768, 32767, 0, -32768));
        // negative x axis on roll and yaw: y zero and both signs of y
        send_matrix(entries(-16384, 0, -16384, 0, 0, 0, -16384));
        send_matrix(entries(-16384, -1, -16384, 1, 0, -1, -16384));
        send_matrix(entries(-16384, 1, -16384, -1, 0, 1, -16384));
        // gimbal lock, pitch at plus and minus ninety degrees
        send_matrix(entries(0, 0, 16384, 0, -16384, 0, 0));
        send_matrix(entries(0, 0, 11585, -11585, 16384, 0, 0));
        send_matrix(entries(0, 0, 0, 0, 0, 0, 0));
        send_matrix(entries(1, 0, -5, 7, 16384, 3, -2));
        send_matrix(rotation(0.3, 1.5707963, -0.7));
        drain_pipe();
    endtask

    task automatic test_limits();
        logic [14:0] settings[5] = '{15'd0, 15'd16384, 15'd32767, 15'd200, 15'd1};
        foreach (settings[k]) begin
            write_limit(settings[k]);
            send_matrix(entries(0, 0, 16384, 0, 16384, 0, 0));
            send_matrix(entries(100, 100, 16384, -300, 16384, 2, 5));
            send_matrix(entries(16384, 0, 16384, 0, 0, 0, 16384));
            send_matrix(rotation(rand_angle(3.14159), rand_angle(1.5708), rand_angle(3.14159)));
        end
        drain_pipe();
    endtask

    task automatic test_random(int count, logic [14:0] limit);
        mat_t m;
        int pick;
        write_limit(limit);
        repeat (count) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                m = rotation(rand_angle(3.14159), rand_angle(1.5708), rand_angle(3.14159));
            end else if (pick < 8) begin
                // close to gimbal lock so that sy straddles the threshold
                m = rotation(rand_angle(3.14159),
                             ($urandom_range(0, 1) ? 1.0 : -1.0) * (1.5708 - rand_angle(0.02)),
                             rand_angle(3.14159));
            end else begin
                m = 112'({$urandom, $urandom, $urandom, $urandom});
            end
            send_matrix(m);
        end
        drain_pipe();
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        gimbal_limit = 15'd1;
        quiet_tail = 1'b0;
        errors = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_limits();
        test_random(250, 15'd1);
        test_random(200, 15'd2000);
        test_random(150, 15'd16384);
        quiet_tail = 1'b1;
        test_random(150, 15'd300);

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
